// ===== src/sorted_priority_queue_top_assert.svh =====
// Assertion macros for the checker of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define SPQ_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Widths, codes and the control bundle shared by the queue's modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic                     load;
    logic                     do_insert;
    logic                     do_remove;
    logic signed [DATA_W-1:0] data;
  } spq_ctrl_t;

endpackage

// ===== src/spq_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;
  logic signed [DATA_W-1:0] head_value;
  logic                     head_valid;

  modport source (output valid, output status, output count, output head_value,
                  output head_valid, input ready);
  modport sink (input valid, input status, input count, input head_value,
                input head_valid, output ready);
endinterface

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with the operand and shifts with its neighbours.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic                     clk,
  input  spq_ctrl_t                ctrl,
  input  logic                     occupied,
  input  logic                     left_gt,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0] entry,
  output logic signed [DATA_W-1:0] entry_next,
  output logic                     gt_occ,
  output logic                     eq_occ
);

  logic gt_q;
  logic eq_q;

  assign gt_occ = occupied && gt_q;
  assign eq_occ = occupied && eq_q;

  always_comb begin
    entry_next = entry;
    if (ctrl.do_insert && !gt_occ) begin
      entry_next = left_gt ? ctrl.data : left_entry;
    end else if (ctrl.do_remove && occupied && !gt_q) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctrl.load) begin
      gt_q <= ctrl.data < entry;
      eq_q <= ctrl.data == entry;
    end
  end

endmodule

// ===== src/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue control
// Sequences each operation, tracks the fill count and registers the response.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  spq_req_if.sink                  req,
  spq_rsp_if.source                rsp,
  input  logic                     found,
  input  logic signed [DATA_W-1:0] head_next,
  output spq_ctrl_t                ctrl,
  output logic [CNT_W-1:0]         count
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                   state;
  action_t                  action_q;
  logic signed [DATA_W-1:0] value_q;
  logic                     rsp_valid;
  status_t                  status_next;
  logic [CNT_W-1:0]         count_next;
  logic                     full;
  logic                     empty;
  logic                     finish;

  assign full   = count >= CNT_W'(DEPTH);
  assign empty  = count == '0;
  assign finish = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  assign req.ready = state == S_IDLE;
  assign rsp.valid = rsp_valid;

  assign ctrl.load      = req.valid && req.ready;
  assign ctrl.data      = (state == S_IDLE) ? req.value : value_q;
  assign ctrl.do_insert = finish && (action_q == ACT_INSERT) && !full;
  assign ctrl.do_remove = finish && (action_q == ACT_REMOVE) && found;

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    case (action_q)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ctrl.load) begin
            action_q <= action_t'(req.action);
            value_q  <= req.value;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (finish) begin
            count          <= count_next;
            rsp_valid      <= 1'b1;
            rsp.status     <= status_next;
            rsp.count      <= COUNT_W'(count_next);
            rsp.head_valid <= count_next != '0;
            rsp.head_value <= (count_next != '0) ? head_next : '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Store kept largest first in a row of cells; inserts and removes by value.
// ----------------------------------------------------------------------------
//   channel  direction  beat contents
//   req      in         action, value
//   rsp      out        status, count, head_value, head_valid
//
// The cells compare the operand on the beat's edge and shift on the edge
// that ends execution, with the response registered on that edge.
// One operation is in flight at a time; req.ready is high while idle.
// A stalled response holds the operation in the shift step until taken.
// Reset empties the queue at once; no clearing sweep is needed.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  spq_ctrl_t                ctrl;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] entry      [DEPTH];
  logic signed [DATA_W-1:0] entry_next [DEPTH];
  logic [DEPTH-1:0]         gt_occ;
  logic [DEPTH-1:0]         eq_occ;
  logic                     found;

  assign found = |eq_occ;

  spq_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .found     (found),
    .head_next (entry_next[0]),
    .ctrl      (ctrl),
    .count     (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     occupied;
    logic                     left_gt;
    logic signed [DATA_W-1:0] left_entry;
    logic signed [DATA_W-1:0] right_entry;

    assign occupied = CNT_W'(i) < count;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b1;
      assign left_entry = entry[0];
    end else begin : g_mid
      assign left_gt    = gt_occ[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .entry_next  (entry_next[i]),
      .gt_occ      (gt_occ[i]),
      .eq_occ      (eq_occ[i])
    );
  end

endmodule

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks of the queue's handshake and response contents.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_assert.svh"

module spq_checker import spq_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [STATUS_W-1:0]      rsp_status,
  input logic [COUNT_W-1:0]       rsp_count,
  input logic signed [DATA_W-1:0] rsp_head_value,
  input logic                     rsp_head_valid
);

  `SPQ_ASSERT_ALWAYS(a_rsp_idle_after_reset, clk, $past(rst) |-> !rsp_valid, "response after reset")
  `SPQ_ASSERT(a_one_in_flight, clk, rst, req_valid && req_ready |=> !req_ready, "second beat taken")
  `SPQ_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_head_value), "stalled response changed")
  `SPQ_ASSERT(a_empty_head, clk, rst, rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && !rsp_head_valid, "empty status with entries")
  `SPQ_ASSERT(a_head_zero, clk, rst, rsp_valid && !rsp_head_valid |-> rsp_head_value == '0, "head value without entry")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_count      (rsp.count),
  .rsp_head_value (rsp.head_value),
  .rsp_head_valid (rsp.head_valid)
);

// ===== verif/sorted_priority_queue_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove beats into the queue and checks every response
// against a shadow store kept in the testbench. Directed beats cover the
// empty, not-found, full, tie and extreme-value cases. A long receiver
// hold-off then stalls a response while the next request waits, and
// biased random traffic with random gaps on both channels follows.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int RANDOM_BEATS   = 1550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int DRAIN_CYCLES   = 10;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 16'sh8000;

  typedef struct packed {
    status_t                  status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] head_value;
    logic                     head_valid;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_top #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count = 0;
  queue_result_t            pending_results [$];
  int                       errors = 0;
  int                       idle_cycles = 0;
  bit                       tx_idle_en = 1'b0;
  bit                       rx_idle_en = 1'b0;
  int                       hold_off_cycles = 0;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic queue_result_t apply_queue_op(action_t act,
                                                  logic signed [DATA_W-1:0] v);
    queue_result_t res;
    int            pos;
    int            k;
    res.status = ST_OK;
    pos = 0;
    if (act == ACT_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        while (pos < shadow_count && v < shadow_entries[pos]) pos++;
        for (k = shadow_count; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[pos] = v;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      while (pos < shadow_count && shadow_entries[pos] != v) pos++;
      if (pos >= shadow_count) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (k = pos; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k+1];
        shadow_count--;
      end
    end
    res.count      = shadow_count[COUNT_W-1:0];
    res.head_valid = (shadow_count > 0);
    res.head_value = (shadow_count > 0) ? shadow_entries[0] : '0;
    return res;
  endfunction

  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        pending_results.push_back(apply_queue_op(action_t'(req_ch.action), req_ch.value));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("response beat arrived with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          end
          if (rsp_ch.count !== want.count) begin
            errors++;
            $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
          end
          if (rsp_ch.head_value !== want.head_value) begin
            errors++;
            $error("head_value: expected %0d, got %0d", want.head_value,
                   rsp_ch.head_value);
          end
          if (rsp_ch.head_valid !== want.head_valid) begin
            errors++;
            $error("head_valid: expected %0d, got %0d", want.head_valid,
                   rsp_ch.head_valid);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : response_sink
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(action_t act, logic signed [DATA_W-1:0] v);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    int near;
    roll = $urandom_range(0, 9);
    if (roll < 4) return DATA_W'($urandom());
    if (roll < 8) begin
      near = int'($urandom_range(0, 15)) - 8;
      return near[DATA_W-1:0];
    end
    case ($urandom_range(0, 3))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic test_empty_and_missing();
    send_item(ACT_REMOVE, '0);
    send_item(ACT_INSERT, VAL_MAX);
    send_item(ACT_INSERT, VAL_MIN);
    send_item(ACT_REMOVE, 16'sd100);
    wait_drained();
  endtask

  task automatic test_extremes_and_ties();
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, '1);
    send_item(ACT_REMOVE, VAL_MIN);
    send_item(ACT_REMOVE, VAL_MAX);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    logic signed [DATA_W-1:0] patterns [4];
    int i;
    patterns = '{16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00};
    for (i = 0; i < 4; i++) send_item(ACT_INSERT, patterns[i]);
    for (i = 0; i < 9; i++) send_item(ACT_INSERT, DATA_W'($urandom()));
    send_item(ACT_INSERT, 16'sd1);
    send_item(ACT_REMOVE, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    int i;
    tx_idle_en = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    for (i = 0; i < 12; i++) send_item(ACT_INSERT, pick_value());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int                       i;
    int                       insert_pct;
    action_t                  act;
    logic signed [DATA_W-1:0] v;
    insert_pct = 50;
    for (i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 150 == 0) begin
        case ((i / 150) % 3)
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      if (act == ACT_REMOVE && shadow_count > 0 && $urandom_range(0, 9) < 7) begin
        v = shadow_entries[$urandom_range(0, shadow_count - 1)];
      end else begin
        v = pick_value();
      end
      send_item(act, v);
    end
    wait_drained();
  endtask

  initial begin
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_INSERT;
    req_ch.value  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_missing();
    test_extremes_and_ties();
    test_fill_to_full();
    test_backpressure();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
